/* sv/nrsh_pkg.sv */
// ----------------------------------------------------------------------------
// nrsh_pkg
// Shared constants and controller/datapath interface types for the
// nearest ray/sphere hit search.
// ----------------------------------------------------------------------------
package nrsh_pkg;

    localparam int MAX_SPHERES_DEF = 16;

    localparam int IN_DATA_W  = 272;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SPHERES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE   = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int MUL_W   = 37;          // operand width of the shared multiplier
    localparam int PROD_W  = 2 * MUL_W;   // product and det accumulator width
    localparam int B24_W   = 49;
    localparam int ROOT_W  = PROD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int T_W     = MUL_W + 2;
    localparam int DIST_W  = 31;

    localparam logic [3:0] STEP_RXDX = 4'd0;
    localparam logic [3:0] STEP_RYDY = 4'd1;
    localparam logic [3:0] STEP_RZDZ = 4'd2;
    localparam logic [3:0] STEP_RXRX = 4'd3;
    localparam logic [3:0] STEP_RYRY = 4'd4;
    localparam logic [3:0] STEP_RZRZ = 4'd5;
    localparam logic [3:0] STEP_RR   = 4'd6;
    localparam logic [3:0] STEP_BB   = 4'd7;
    localparam logic [3:0] STEP_LAST = 4'd8;

    typedef struct packed {
        logic       load;
        logic       query;
        logic       rd;
        logic       diff;
        logic       mul;
        logic [3:0] step;
        logic       sq_init;
        logic       sq_step;
        logic       eval;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic det_neg;
        logic out_valid;
    } t_sts;

endpackage

/* sv/nrsh_datapath.sv */
// ----------------------------------------------------------------------------
// nrsh_datapath
// Sphere table, shared multiplier with accumulators, digit-serial square
// root, nearest-hit tracking and the result register.
// ----------------------------------------------------------------------------
module nrsh_datapath #(
    parameter int MAX_SPHERES = nrsh_pkg::MAX_SPHERES_DEF,
    parameter int IW          = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1,
    parameter int NW          = $clog2(MAX_SPHERES + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nrsh_pkg::t_cmd                    i_cmd,
    input  logic [IW-1:0]                     i_idx,
    output nrsh_pkg::t_sts                    o_sts,
    output logic [NW-1:0]                     o_n_lim,
    input  logic                              i_cfg_we,
    input  logic [nrsh_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [nrsh_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [nrsh_pkg::IN_DATA_W-1:0]    i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [nrsh_pkg::OUT_DATA_W-1:0]   o_data,
    output logic                              o_hit
);
    import nrsh_pkg::*;

    logic [4:0]               r_use;
    logic [12:0]              r_min;

    logic [95:0]              r_cen [MAX_SPHERES];
    logic [30:0]              r_rad [MAX_SPHERES];
    logic [95:0]              r_rd_cen;
    logic [30:0]              r_rd_rad;

    logic signed [31:0]       r_org [3];
    logic signed [13:0]       r_dir [3];
    logic signed [32:0]       r_rs  [3];
    logic [30:0]              r_r;

    logic signed [MUL_W-1:0]  ma, mb;
    logic signed [PROD_W-1:0] r_prod;
    logic [3:0]               r_pstep;
    logic                     r_pvalid;
    logic signed [B24_W-1:0]  r_b24;
    logic signed [PROD_W-1:0] r_det;
    logic signed [MUL_W-1:0]  b;

    logic [PROD_W-1:0]        r_sq_in;
    logic [REM_W-1:0]         r_rem;
    logic [ROOT_W-1:0]        r_root;
    logic [REM_W-1:0]         remn, trial;

    logic signed [T_W-1:0]    t1, t2, md, t_sel;
    logic                     t_ok;
    logic                     r_found;
    logic signed [T_W-1:0]    r_best;
    logic [IW-1:0]            r_best_idx;

    logic                     r_out_valid;
    logic                     r_o_hit;
    logic [DIST_W-1:0]        r_o_dist;
    logic [3:0]               r_o_entry;

    logic [IW-1:0]            wa;

    assign wa = IW'(i_data[3:0]);
    assign b  = r_b24[B24_W-1:12];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= '0;
            r_min <= 13'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPHERES_IN_USE: r_use <= i_cfg_data[4:0];
                REG_MIN_DISTANCE:   r_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_n_lim = (int'(r_use) > MAX_SPHERES) ? NW'(MAX_SPHERES) : NW'(r_use);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (int'(i_data[3:0]) < MAX_SPHERES)) begin
            r_cen[wa] <= i_data[99:4];
            r_rad[wa] <= i_data[130:100];
        end
        if (i_cmd.rd) begin
            r_rd_cen <= r_cen[i_idx];
            r_rd_rad <= r_rad[i_idx];
        end
    end

    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.step)
            STEP_RXDX: begin ma = MUL_W'(r_rs[0]); mb = MUL_W'(r_dir[0]); end
            STEP_RYDY: begin ma = MUL_W'(r_rs[1]); mb = MUL_W'(r_dir[1]); end
            STEP_RZDZ: begin ma = MUL_W'(r_rs[2]); mb = MUL_W'(r_dir[2]); end
            STEP_RXRX: begin ma = MUL_W'(r_rs[0]); mb = MUL_W'(r_rs[0]); end
            STEP_RYRY: begin ma = MUL_W'(r_rs[1]); mb = MUL_W'(r_rs[1]); end
            STEP_RZRZ: begin ma = MUL_W'(r_rs[2]); mb = MUL_W'(r_rs[2]); end
            STEP_RR: begin
                ma = $signed({6'b0, r_r});
                mb = $signed({6'b0, r_r});
            end
            STEP_BB: begin ma = b; mb = b; end
            default: ;
        endcase
    end

    always_comb begin
        remn  = {r_rem[REM_W-3:0], r_sq_in[PROD_W-1 -: 2]};
        trial = REM_W'({r_root, 2'b01});
    end

    always_comb begin
        t1    = T_W'(b) - $signed({2'b0, r_root});
        t2    = T_W'(b) + $signed({2'b0, r_root});
        md    = $signed({{(T_W-13){1'b0}}, r_min});
        t_ok  = 1'b1;
        t_sel = t1;
        if (t1 <= md) begin
            t_sel = t2;
            if (t2 <= md)
                t_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_org[0] <= $signed(i_data[162:131]);
            r_org[1] <= $signed(i_data[194:163]);
            r_org[2] <= $signed(i_data[226:195]);
            r_dir[0] <= $signed(i_data[240:227]);
            r_dir[1] <= $signed(i_data[254:241]);
            r_dir[2] <= $signed(i_data[268:255]);
        end
        if (i_cmd.diff) begin
            for (int a = 0; a < 3; a++)
                r_rs[a] <= $signed({r_rd_cen[32*a+31], r_rd_cen[32*a +: 32]})
                         - $signed({r_org[a][31], r_org[a]});
            r_r   <= r_rd_rad;
            r_b24 <= '0;
            r_det <= '0;
        end else if (r_pvalid) begin
            case (r_pstep)
                STEP_RXDX, STEP_RYDY, STEP_RZDZ:
                    r_b24 <= r_b24 + $signed(r_prod[B24_W-1:0]);
                STEP_RXRX, STEP_RYRY, STEP_RZRZ:
                    r_det <= r_det - r_prod;
                default:
                    r_det <= r_det + r_prod;
            endcase
        end
        r_prod  <= PROD_W'(ma) * PROD_W'(mb);
        r_pstep <= i_cmd.step;
        if (i_cmd.sq_init) begin
            r_sq_in <= r_det;
            r_rem   <= '0;
            r_root  <= '0;
        end else if (i_cmd.sq_step) begin
            r_sq_in <= {r_sq_in[PROD_W-3:0], 2'b00};
            if (remn >= trial) begin
                r_rem  <= remn - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= remn;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.eval && t_ok && (!r_found || (t_sel < r_best))) begin
            r_best     <= t_sel;
            r_best_idx <= i_idx;
        end
        if (i_cmd.out_load) begin
            r_o_hit   <= r_found;
            r_o_dist  <= !r_found ? '1 :
                         (|r_best[T_W-1:DIST_W]) ? '1 : r_best[DIST_W-1:0];
            r_o_entry <= r_found ? 4'(r_best_idx) : 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pvalid <= i_cmd.mul && (i_cmd.step != STEP_LAST);
            if (i_cmd.query)
                r_found <= 1'b0;
            else if (i_cmd.eval && t_ok)
                r_found <= 1'b1;
            if (i_cmd.out_load)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_sts.det_neg   = r_det[PROD_W-1];
    assign o_sts.out_valid = r_out_valid;
    assign o_valid         = r_out_valid;
    assign o_hit           = r_o_hit;
    assign o_data          = {5'b0, r_o_entry, r_o_dist};

endmodule

/* sv/nrsh_ctrl.sv */
// ----------------------------------------------------------------------------
// nrsh_ctrl
// Sequencer: takes items, walks the sphere table and steps the datapath
// through multiply and, for entries not missed, square root and compare.
// ----------------------------------------------------------------------------
module nrsh_ctrl #(
    parameter int MAX_SPHERES = nrsh_pkg::MAX_SPHERES_DEF,
    parameter int IW          = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1,
    parameter int NW          = $clog2(MAX_SPHERES + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_op,
    output nrsh_pkg::t_cmd  o_cmd,
    output logic [IW-1:0]   o_idx,
    input  nrsh_pkg::t_sts  i_sts,
    input  logic [NW-1:0]   i_n_lim
);
    import nrsh_pkg::*;

    typedef enum logic [2:0] {
        IDLE, FETCH, DIFF, MUL, SQINIT, SQRT, EVAL, WAIT_OUT
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [5:0]    r_cnt, n_cnt;
    logic          last;

    assign last    = (NW'(r_idx) + NW'(1)) == i_n_lim;
    assign o_ready = (r_state == IDLE);
    assign o_idx   = r_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.query = 1'b1;
                        n_idx       = '0;
                        n_state     = (i_n_lim == '0) ? WAIT_OUT : FETCH;
                    end
                end
            end
            FETCH: begin
                o_cmd.rd = 1'b1;
                n_state  = DIFF;
            end
            DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt      = '0;
                n_state    = MUL;
            end
            MUL: begin
                o_cmd.mul  = 1'b1;
                o_cmd.step = r_cnt[3:0];
                n_cnt      = r_cnt + 6'd1;
                if (r_cnt[3:0] == STEP_LAST)
                    n_state = SQINIT;
            end
            SQINIT: begin
                n_cnt = '0;
                if (i_sts.det_neg) begin
                    n_idx   = last ? r_idx : r_idx + IW'(1);
                    n_state = last ? WAIT_OUT : FETCH;
                end else begin
                    o_cmd.sq_init = 1'b1;
                    n_state       = SQRT;
                end
            end
            SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 6'd1;
                if (r_cnt == 6'(ROOT_W - 1))
                    n_state = EVAL;
            end
            EVAL: begin
                o_cmd.eval = 1'b1;
                n_idx      = last ? r_idx : r_idx + IW'(1);
                n_state    = last ? WAIT_OUT : FETCH;
            end
            WAIT_OUT: begin
                if (!i_sts.out_valid) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = IDLE;
                end
            end
            default: n_state = IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_valid) else $error("result overwritten");
    a_sqrt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQRT) |-> !i_sts.det_neg) else $error("root of negative det");
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |-> (NW'(r_idx) < i_n_lim)) else $error("entry beyond spheres in use");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != IDLE) |=> !$past(o_cmd.load)) else $error("load while busy");
`endif

endmodule

/* sv/nearest_ray_sphere_hit.sv */
// ----------------------------------------------------------------------------
// nearest_ray_sphere_hit
// Nearest hit of a ray against a table of spheres, fixed point.
// ----------------------------------------------------------------------------
// Input items on s_axis: tuser is op (0 load, 1 query). A load writes one
// table entry and gives no result. A query walks entries
// 0 .. spheres_in_use-1 and gives one result item on m_axis.
// A query handles each entry with one shared multiplier over 8 products;
// an entry missed by the quadratic test stops there, the others then go
// through a bit-serial root and a compare. A new item is taken only once
// the previous one is done.
// Result: tuser is hit; tdata holds distance and hit_entry. The result sits
// in an output register, so the next item is taken while it waits; a query
// that finishes while the old result is still stalled waits for it to go.
// Reset (synchronous, active low) clears control state and sets
// spheres_in_use to 0 and min_distance to 1; the table is not cleared.
// Configuration writes are taken in any cycle; write them only when idle.
// ----------------------------------------------------------------------------
module nearest_ray_sphere_hit #(
    parameter int MAX_SPHERES = nrsh_pkg::MAX_SPHERES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entry_index, center_x, center_y, center_z, radius, origin_x,
    // origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [nrsh_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,   // op
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // distance, hit_entry, zero pad
    output logic [nrsh_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser,   // hit
    input  logic                             i_cfg_we,
    input  logic [nrsh_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [nrsh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import nrsh_pkg::*;

    localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int NW = $clog2(MAX_SPHERES + 1);

    t_cmd          cmd;
    t_sts          sts;
    logic [IW-1:0] idx;
    logic [NW-1:0] n_lim;

    nrsh_ctrl #(.MAX_SPHERES(MAX_SPHERES), .IW(IW), .NW(NW)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .o_cmd   (cmd),
        .o_idx   (idx),
        .i_sts   (sts),
        .i_n_lim (n_lim)
    );

    nrsh_datapath #(.MAX_SPHERES(MAX_SPHERES), .IW(IW), .NW(NW)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_idx      (idx),
        .o_sts      (sts),
        .o_n_lim    (n_lim),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (s_axis_tdata),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_hit      (m_axis_tuser)
    );

endmodule
